[design/ftpr_pkg.sv]
package ftpr_pkg;

  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 8;

  localparam logic [CfgAddrW-1:0] CFG_START = 3'd0;
  localparam logic [CfgAddrW-1:0] CFG_DATA  = 3'd1;
  localparam logic [CfgAddrW-1:0] CFG_END   = 3'd2;
  localparam logic [CfgAddrW-1:0] CFG_SIZE  = 3'd3;
  localparam logic [CfgAddrW-1:0] CFG_NAME  = 3'd4;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_UNK   = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_UNKNOWN = 3'd1;
  localparam logic [2:0] ST_BADCTL  = 3'd2;
  localparam logic [2:0] ST_SHORT   = 3'd3;
  localparam logic [2:0] ST_NOSTART = 3'd4;
  localparam logic [2:0] ST_LENMIS  = 3'd5;

  localparam logic [16:0] IDX_MAX = 17'h1FFFF;

  typedef struct packed {
    logic [7:0] pkt_byte;
    logic       pkt_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        pkt_done;
    logic [1:0]  pkt_kind;
    logic [2:0]  status;
    logic        name_mismatch;
    logic        size_mismatch;
    logic        count_mismatch;
    logic        done_sticky;
    logic [63:0] expected_size;
    logic [63:0] written_total;
  } out_item_t;

  typedef struct packed {
    logic [7:0] start_code;
    logic [7:0] data_code;
    logic [7:0] end_code;
    logic [7:0] size_tag;
    logic [7:0] name_tag;
  } cfg_t;

endpackage

[design/ftpr_name_mem.sv]
module ftpr_name_mem import ftpr_pkg::*; #(
  parameter int Depth = 510,
  parameter int AddrW = 9
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [7:0]       wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [7:0]       rdata
);

  logic [7:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/file_transfer_packet_receiver.sv]
// Packet receiver for a TLV-framed file transfer. Takes one packet byte per
// cycle and returns one result a byte while not stalled. A byte enters stage
// 1, where the name store (two banks of NAME_MAX-1 bytes, one synchronous
// read port) is read at the committed-bank position of the next name byte;
// stage 2 does the parse and name compare and registers the result. The output
// register holds while stalled, and the input is taken when stage 1 is empty
// or moves on. No clearing pass is needed.
module file_transfer_packet_receiver import ftpr_pkg::*; #(
  parameter int NAME_MAX = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_index,
  input  logic [CfgDataW-1:0] cfg_value
);

  localparam int NameCap = NAME_MAX - 1;
  localparam int Depth   = 2 * NameCap;
  localparam int AddrW   = $clog2(Depth);
  localparam int LenW    = $clog2(NAME_MAX);

  typedef enum logic [2:0] {
    PH_CTRL, PH_TYPE, PH_LEN, PH_VAL, PH_DHI, PH_DLO, PH_PAY, PH_SKIP
  } phase_t;

  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{start_code: 8'd2, data_code: 8'd1, end_code: 8'd3,
               size_tag: 8'd0, name_tag: 8'd1};
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START: cfg.start_code <= cfg_value;
        CFG_DATA:  cfg.data_code  <= cfg_value;
        CFG_END:   cfg.end_code   <= cfg_value;
        CFG_SIZE:  cfg.size_tag   <= cfg_value;
        CFG_NAME:  cfg.name_tag   <= cfg_value;
        default: ;
      endcase
    end
  end

  // Stage 1 holds one byte while the store read is in flight.
  logic     s1_valid;
  in_item_t s1_data;
  logic     adv;

  assign adv      = s1_valid && !(out_valid && out_stall);
  assign in_stall = s1_valid && !adv;

  phase_t      phase;
  logic [16:0] byte_index;
  logic [7:0]  field_type, field_remaining;
  logic        seen_name, seen_size;
  logic [63:0] size_accum;
  logic [15:0] decl_len;
  logic [LenW-1:0] name_len [2];
  logic        cbank, name_equal, transfer_open, done_flag, ctl_is_end;
  logic [63:0] committed_size, byte_total;

  // Read address: committed bank at the working count, which stage 2 either
  // keeps or advances by one on this cycle's update.
  logic            nm_we;
  logic [AddrW-1:0] nm_waddr, nm_raddr;
  logic [7:0]      nm_rdata;
  logic [LenW-1:0] wlen_next;

  ftpr_name_mem #(.Depth(Depth), .AddrW(AddrW)) u_mem (
    .clk(clk), .we(nm_we), .waddr(nm_waddr), .wdata(s1_data.pkt_byte),
    .raddr(nm_raddr), .rdata(nm_rdata)
  );

  // next-state
  phase_t      phase_next;
  logic [16:0] byte_index_next;
  logic [7:0]  field_type_next, field_remaining_next;
  logic        seen_name_next, seen_size_next;
  logic [63:0] size_accum_next, committed_size_next, byte_total_next;
  logic [15:0] decl_len_next;
  logic [LenW-1:0] len_w_next;
  logic        cbank_next, name_equal_next, open_next, done_next, ctl_end_next;
  out_item_t   res;
  logic        wb;
  logic [LenW-1:0] clen, wlen;
  logic [7:0]  b;

  assign wb   = ~cbank;
  assign clen = name_len[cbank];
  assign wlen = name_len[wb];
  assign b    = s1_data.pkt_byte;

  always_comb begin
    logic fin, is_size, is_name;
    logic [1:0] kind;
    logic [2:0] st;
    fin = 1'b0;
    kind = KIND_START;
    st = ST_OK;
    phase_next = phase;
    byte_index_next = byte_index;
    field_type_next = field_type;
    field_remaining_next = field_remaining;
    seen_name_next = seen_name;
    seen_size_next = seen_size;
    size_accum_next = size_accum;
    decl_len_next = decl_len;
    len_w_next = wlen;
    cbank_next = cbank;
    name_equal_next = name_equal;
    committed_size_next = committed_size;
    byte_total_next = byte_total;
    open_next = transfer_open;
    done_next = done_flag;
    ctl_end_next = ctl_is_end;
    nm_we = 1'b0;
    res = '0;
    is_size = (field_type == cfg.size_tag);
    is_name = !is_size && (field_type == cfg.name_tag);
    unique case (phase)
      PH_CTRL: begin
        seen_name_next = 1'b0;
        seen_size_next = 1'b0;
        if (b == cfg.start_code || b == cfg.end_code) begin
          ctl_end_next = (b != cfg.start_code);
          phase_next = PH_TYPE;
          kind = ctl_end_next ? KIND_END : KIND_START;
        end else if (b == cfg.data_code) begin
          phase_next = PH_DHI;
          kind = KIND_DATA;
        end else begin
          phase_next = PH_SKIP;
          kind = KIND_UNK;
        end
      end
      PH_TYPE: begin
        field_type_next = b;
        phase_next = PH_LEN;
      end
      PH_LEN: begin
        field_remaining_next = b;
        if (is_size) begin
          size_accum_next = '0;
        end else if (is_name) begin
          len_w_next = '0;
          name_equal_next = 1'b1;
        end
        if (b == 8'd0) begin
          fin = 1'b1;
          phase_next = PH_TYPE;
        end else begin
          phase_next = PH_VAL;
        end
      end
      PH_VAL: begin
        if (is_size) begin
          size_accum_next = {size_accum[55:0], b};
        end else if (is_name && (32'(wlen) < NameCap)) begin
          if (wlen >= clen || nm_rdata != b) name_equal_next = 1'b0;
          nm_we = adv;
          len_w_next = wlen + LenW'(1);
        end
        field_remaining_next = field_remaining - 8'd1;
        if (field_remaining == 8'd1) begin
          fin = 1'b1;
          phase_next = PH_TYPE;
        end
      end
      PH_DHI: begin
        decl_len_next = {b, 8'd0};
        phase_next = PH_DLO;
      end
      PH_DLO: begin
        decl_len_next = {decl_len[15:8], b};
        byte_index_next = '0;
        phase_next = PH_PAY;
      end
      PH_PAY: begin
        if (transfer_open && byte_index < {1'b0, decl_len}) begin
          res.payload_valid = 1'b1;
          res.payload_byte = b;
        end
        if (byte_index != IDX_MAX) byte_index_next = byte_index + 17'd1;
      end
      default: ;
    endcase
    if (fin) begin
      if (is_size) seen_size_next = 1'b1;
      else if (is_name) begin
        seen_name_next = 1'b1;
        if (len_w_next != clen) name_equal_next = 1'b0;
      end
    end
    if (s1_data.pkt_last) begin
      unique case (phase)
        PH_CTRL: ;
        PH_SKIP: kind = KIND_UNK;
        PH_DHI, PH_DLO, PH_PAY: kind = KIND_DATA;
        default: kind = ctl_is_end ? KIND_END : KIND_START;
      endcase
      if (kind == KIND_UNK) begin
        st = ST_UNKNOWN;
      end else if (kind == KIND_DATA) begin
        if (phase_next == PH_DHI || phase_next == PH_DLO) st = ST_SHORT;
        else if (!transfer_open) st = ST_NOSTART;
        else if (byte_index_next != {1'b0, decl_len_next}) st = ST_LENMIS;
        else byte_total_next = byte_total + 64'(decl_len_next);
      end else if (phase_next == PH_VAL || !seen_name_next || !seen_size_next) begin
        st = ST_BADCTL;
      end else if (kind == KIND_START) begin
        cbank_next = ~cbank;
        committed_size_next = size_accum_next;
        byte_total_next = '0;
        open_next = 1'b1;
      end else begin
        open_next = 1'b0;
        res.name_mismatch = !name_equal_next;
        res.size_mismatch = committed_size != size_accum_next;
        res.count_mismatch = byte_total != committed_size;
        done_next = 1'b1;
      end
      phase_next = PH_CTRL;
    end else begin
      kind = KIND_START;
    end
    res.pkt_done = s1_data.pkt_last;
    res.pkt_kind = kind;
    res.status = st;
    res.done_sticky = done_next;
    res.expected_size = committed_size_next;
    res.written_total = byte_total_next;
  end

  assign nm_waddr = AddrW'(32'(wb) * NameCap + 32'(wlen));

  // Next byte's lookup: committed bank after update, working count after update.
  assign wlen_next = adv ? len_w_next : wlen;
  always_comb begin
    logic bk;
    bk = adv ? cbank_next : cbank;
    nm_raddr = AddrW'(32'(bk) * NameCap + 32'(wlen_next));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
      phase <= PH_CTRL;
      byte_index <= '0;
      field_type <= '0;
      field_remaining <= '0;
      seen_name <= 1'b0;
      seen_size <= 1'b0;
      size_accum <= '0;
      decl_len <= '0;
      name_len[0] <= '0;
      name_len[1] <= '0;
      cbank <= 1'b0;
      name_equal <= 1'b0;
      committed_size <= '0;
      byte_total <= '0;
      transfer_open <= 1'b0;
      done_flag <= 1'b0;
      ctl_is_end <= 1'b0;
    end else begin
      if (adv) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (adv) begin
        out_data <= res;
        phase <= phase_next;
        byte_index <= byte_index_next;
        field_type <= field_type_next;
        field_remaining <= field_remaining_next;
        seen_name <= seen_name_next;
        seen_size <= seen_size_next;
        size_accum <= size_accum_next;
        decl_len <= decl_len_next;
        name_len[wb] <= len_w_next;
        cbank <= cbank_next;
        name_equal <= name_equal_next;
        committed_size <= committed_size_next;
        byte_total <= byte_total_next;
        transfer_open <= open_next;
        done_flag <= done_next;
        ctl_is_end <= ctl_end_next;
      end
      if (in_valid && !in_stall) begin
        s1_valid <= 1'b1;
        s1_data <= in_data;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    done_flag |=> done_flag) else $error("done flag cleared");
  a_pay_only_data: assert property (@(posedge clk) disable iff (rst)
    (adv && res.payload_valid) |-> (phase == PH_PAY && transfer_open))
    else $error("payload outside data packet");
  a_kind_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.pkt_done) |-> (out_data.pkt_kind == KIND_START
      && out_data.status == ST_OK)) else $error("kind or status mid-packet");
  a_name_len: assert property (@(posedge clk) disable iff (rst)
    32'(name_len[0]) <= NameCap && 32'(name_len[1]) <= NameCap)
    else $error("name length overflow");
`endif

endmodule

[verif/file_transfer_packet_receiver_test.sv]
module file_transfer_packet_receiver_test;
  import ftpr_pkg::*;

  typedef enum logic [3:0] {
    P_CTRL, P_TYPE, P_LEN, P_VAL, P_DHI, P_DLO, P_PAY, P_SKIP
  } parse_ph_t;

  localparam int NameCap = 255;
  localparam int StallLimit = 5000;

  class rx_scoreboard;
    cfg_t        cfg;
    parse_ph_t   ph;
    logic [16:0] bidx;
    logic [7:0]  ftype;
    logic [7:0]  frem;
    bit          seen_name, seen_size, neq, topen, done, is_end;
    logic [63:0] size_acc, csize, btotal;
    logic [15:0] dlen;
    logic [7:0]  nst [2*NameCap];
    int          nlen [2];
    int          cbank;
    int          errors;
    out_item_t   expected_results [$];

    function new();
      cfg = '{start_code: 8'd2, data_code: 8'd1, end_code: 8'd3,
              size_tag: 8'd0, name_tag: 8'd1};
      ph = P_CTRL;
      bidx = '0; ftype = '0; frem = '0; dlen = '0;
      seen_name = 0; seen_size = 0; neq = 0; topen = 0; done = 0; is_end = 0;
      size_acc = '0; csize = '0; btotal = '0;
      foreach (nst[i]) nst[i] = '0;
      nlen[0] = 0; nlen[1] = 0;
      cbank = 0; errors = 0;
    endfunction

    function void set_reg(logic [CfgAddrW-1:0] idx, logic [7:0] v);
      case (idx)
        CFG_START: cfg.start_code = v;
        CFG_DATA:  cfg.data_code = v;
        CFG_END:   cfg.end_code = v;
        CFG_SIZE:  cfg.size_tag = v;
        CFG_NAME:  cfg.name_tag = v;
        default: ;
      endcase
    endfunction

    function void field_begin();
      if (ftype == cfg.size_tag) size_acc = '0;
      else if (ftype == cfg.name_tag) begin
        nlen[cbank ^ 1] = 0;
        neq = 1;
      end
    endfunction

    function void field_finish();
      if (ftype == cfg.size_tag) seen_size = 1;
      else if (ftype == cfg.name_tag) begin
        seen_name = 1;
        if (nlen[cbank ^ 1] != nlen[cbank]) neq = 0;
      end
    endfunction

    function void field_value(logic [7:0] b);
      int wk;
      int cnt;
      wk = cbank ^ 1;
      if (ftype == cfg.size_tag) size_acc = {size_acc[55:0], b};
      else if (ftype == cfg.name_tag) begin
        cnt = nlen[wk];
        if (cnt < NameCap) begin
          if (cnt >= nlen[cbank] || nst[cbank*NameCap + cnt] != b) neq = 0;
          nst[wk*NameCap + cnt] = b;
          nlen[wk] = cnt + 1;
        end
      end
    endfunction

    function void note(in_item_t it);
      out_item_t e;
      logic [7:0] b;
      bit last, pv, nm, sm, cm;
      logic [1:0] kind;
      logic [2:0] st;
      parse_ph_t np;
      b = it.pkt_byte; last = it.pkt_last;
      pv = 0; nm = 0; sm = 0; cm = 0; kind = KIND_START; st = ST_OK; np = ph;
      case (ph)
        P_CTRL: begin
          seen_name = 0; seen_size = 0;
          if (b == cfg.start_code || b == cfg.end_code) begin
            is_end = (b != cfg.start_code);
            np = P_TYPE;
          end else if (b == cfg.data_code) np = P_DHI;
          else np = P_SKIP;
          kind = (np == P_TYPE) ? (is_end ? KIND_END : KIND_START) :
                 (np == P_DHI) ? KIND_DATA : KIND_UNK;
        end
        P_TYPE: begin
          ftype = b; np = P_LEN;
        end
        P_LEN: begin
          frem = b;
          field_begin();
          if (b == 0) begin
            field_finish(); np = P_TYPE;
          end else np = P_VAL;
        end
        P_VAL: begin
          field_value(b);
          frem = frem - 8'd1;
          if (frem == 0) begin
            field_finish(); np = P_TYPE;
          end
        end
        P_DHI: begin
          dlen = {b, 8'h00}; np = P_DLO;
        end
        P_DLO: begin
          dlen[7:0] = b; bidx = '0; np = P_PAY;
        end
        P_PAY: begin
          if (topen && bidx < {1'b0, dlen}) pv = 1;
          if (bidx < IDX_MAX) bidx = bidx + 17'd1;
        end
        default: ;
      endcase
      if (last) begin
        if (ph == P_CTRL) ;
        else if (ph == P_SKIP) kind = KIND_UNK;
        else if (ph == P_DHI || ph == P_DLO || ph == P_PAY) kind = KIND_DATA;
        else kind = is_end ? KIND_END : KIND_START;
        if (kind == KIND_UNK) st = ST_UNKNOWN;
        else if (kind == KIND_DATA) begin
          if (np == P_DHI || np == P_DLO) st = ST_SHORT;
          else if (!topen) st = ST_NOSTART;
          else if (bidx != {1'b0, dlen}) st = ST_LENMIS;
          else btotal = btotal + {48'd0, dlen};
        end else begin
          if (np == P_VAL || !seen_name || !seen_size) st = ST_BADCTL;
          else if (kind == KIND_START) begin
            cbank = cbank ^ 1;
            csize = size_acc;
            btotal = '0;
            topen = 1;
          end else begin
            topen = 0;
            nm = !neq;
            sm = csize != size_acc;
            cm = btotal != csize;
            done = 1;
          end
        end
        np = P_CTRL;
      end else kind = KIND_START;
      ph = np;
      e.payload_byte = pv ? b : 8'd0;
      e.payload_valid = pv;
      e.pkt_done = last;
      e.pkt_kind = kind;
      e.status = st;
      e.name_mismatch = nm;
      e.size_mismatch = sm;
      e.count_mismatch = cm;
      e.done_sticky = done;
      e.expected_size = csize;
      e.written_total = btotal;
      expected_results.push_back(e);
    endfunction

    function void check(out_item_t a);
      out_item_t e;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected");
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (a.payload_byte !== e.payload_byte) begin
        $error("payload_byte exp %0h got %0h", e.payload_byte, a.payload_byte); errors++;
      end
      if (a.payload_valid !== e.payload_valid) begin
        $error("payload_valid exp %0h got %0h", e.payload_valid, a.payload_valid); errors++;
      end
      if (a.pkt_done !== e.pkt_done) begin
        $error("pkt_done exp %0h got %0h", e.pkt_done, a.pkt_done); errors++;
      end
      if (a.pkt_kind !== e.pkt_kind) begin
        $error("pkt_kind exp %0h got %0h", e.pkt_kind, a.pkt_kind); errors++;
      end
      if (a.status !== e.status) begin
        $error("status exp %0h got %0h", e.status, a.status); errors++;
      end
      if (a.name_mismatch !== e.name_mismatch) begin
        $error("name_mismatch exp %0h got %0h", e.name_mismatch, a.name_mismatch); errors++;
      end
      if (a.size_mismatch !== e.size_mismatch) begin
        $error("size_mismatch exp %0h got %0h", e.size_mismatch, a.size_mismatch); errors++;
      end
      if (a.count_mismatch !== e.count_mismatch) begin
        $error("count_mismatch exp %0h got %0h", e.count_mismatch, a.count_mismatch);
        errors++;
      end
      if (a.done_sticky !== e.done_sticky) begin
        $error("done_sticky exp %0h got %0h", e.done_sticky, a.done_sticky); errors++;
      end
      if (a.expected_size !== e.expected_size) begin
        $error("expected_size exp %0h got %0h", e.expected_size, a.expected_size); errors++;
      end
      if (a.written_total !== e.written_total) begin
        $error("written_total exp %0h got %0h", e.written_total, a.written_total); errors++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_stall;
  out_item_t           out_data;
  logic                cfg_we;
  logic [CfgAddrW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_value;

  file_transfer_packet_receiver i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_value(cfg_value)
  );

  rx_scoreboard sb = new();

  logic        iv_n, is_n, ov_n, os_n;
  in_item_t    id_n;
  out_item_t   od_n;
  bit          quiet;
  bit          hold_req;
  int          n_sent, n_in, n_out, idle_cycles;
  logic [7:0]  pkt_q [$];
  logic [7:0]  cur_name [NameCap];
  int          cur_nlen;
  longint unsigned cur_size;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    iv_n = in_valid; is_n = in_stall; id_n = in_data;
    ov_n = out_valid; os_n = out_stall; od_n = out_data;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (iv_n && !is_n) begin
        sb.note(id_n);
        n_in++;
      end
      if (ov_n && !os_n) begin
        sb.check(od_n);
        n_out++;
      end
      if ((iv_n && !is_n) || (ov_n && !os_n)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > StallLimit) begin
        $display("file_transfer_packet_receiver_test NOT OK");
        $finish;
      end
    end
  end

  // receiver side
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_req = 0;
      end else out_stall <= !quiet && ($urandom_range(0, 99) < 20);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    if (!quiet && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{pkt_byte: b, pkt_last: l};
    n_sent++;
    do @(posedge clk); while (!(iv_n && !is_n));
  endtask

  task automatic send_pkt();
    foreach (pkt_q[i]) send_byte(pkt_q[i], i == pkt_q.size() - 1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_value <= v;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic set_codes(input logic [7:0] s, d, e, st, nt);
    drain();
    write_reg(CFG_START, s);
    write_reg(CFG_DATA, d);
    write_reg(CFG_END, e);
    write_reg(CFG_SIZE, st);
    write_reg(CFG_NAME, nt);
    cfg_we <= 1'b0;
  endtask

  task automatic new_name(input int n);
    cur_nlen = n;
    for (int i = 0; i < n; i++) cur_name[i] = 8'($urandom_range(0, 255));
  endtask

  task automatic put_name(input int n);
    pkt_q.push_back(sb.cfg.name_tag);
    pkt_q.push_back(8'(n));
    for (int i = 0; i < n; i++) pkt_q.push_back(cur_name[i]);
  endtask

  task automatic put_size(input longint unsigned v, input int len);
    pkt_q.push_back(sb.cfg.size_tag);
    pkt_q.push_back(8'(len));
    for (int i = len - 1; i >= 0; i--)
      pkt_q.push_back(i < 8 ? 8'(v >> (8 * i)) : 8'($urandom_range(0, 255)));
  endtask

  // control packet: name from cur_name, size cur_size
  task automatic ctl_pkt(input logic [7:0] code, input bit has_name, has_size,
                         input int slen, input bit trail, input int cut,
                         input bit extra);
    pkt_q.delete();
    pkt_q.push_back(code);
    if (extra) begin
      pkt_q.push_back(8'($urandom_range(0, 255)));
      pkt_q.push_back(8'($urandom_range(0, 2)));
      repeat (pkt_q[pkt_q.size()-1]) pkt_q.push_back(8'($urandom_range(0, 255)));
      put_size(64'($urandom), $urandom_range(0, 3));
    end
    if ($urandom_range(0, 1)) begin
      if (has_size) put_size(cur_size, slen);
      if (has_name) put_name(cur_nlen);
    end else begin
      if (has_name) put_name(cur_nlen);
      if (has_size) put_size(cur_size, slen);
    end
    if (trail) pkt_q.push_back(8'($urandom_range(0, 255)));
    while (cut > 0 && pkt_q.size() > cut) void'(pkt_q.pop_back());
    send_pkt();
  endtask

  task automatic data_pkt(input logic [15:0] len, input int npay, input int cut);
    pkt_q.delete();
    pkt_q.push_back(sb.cfg.data_code);
    pkt_q.push_back(len[15:8]);
    pkt_q.push_back(len[7:0]);
    repeat (npay) pkt_q.push_back(8'($urandom_range(0, 255)));
    while (cut > 0 && pkt_q.size() > cut) void'(pkt_q.pop_back());
    send_pkt();
  endtask

  task automatic unk_pkt(input int n);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == sb.cfg.start_code || c == sb.cfg.data_code || c == sb.cfg.end_code);
    pkt_q.delete();
    pkt_q.push_back(c);
    repeat (n - 1) pkt_q.push_back(8'($urandom_range(0, 255)));
    send_pkt();
  endtask

  function automatic int size_bytes(longint unsigned v);
    int n;
    n = 0;
    while (n < 8 && (v >> (8 * n)) != 0) n++;
    return n;
  endfunction

  task automatic rand_transfer();
    int rem, chunk, sl;
    bit bad;
    if ($urandom_range(0, 99) < 85) begin
      new_name($urandom_range(0, 99) < 3 ? NameCap : $urandom_range(0, 6));
      cur_size = 64'($urandom_range(0, 12));
      sl = size_bytes(cur_size) + $urandom_range(0, 2);
      bad = $urandom_range(0, 9) == 0;
      ctl_pkt(sb.cfg.start_code, !bad || $urandom_range(0, 1), !bad || $urandom_range(0, 1),
              sl, $urandom_range(0, 9) == 0, bad ? $urandom_range(1, 6) : 0,
              $urandom_range(0, 4) == 0);
      rem = int'(cur_size);
      while (rem > 0) begin
        chunk = $urandom_range(1, rem);
        if ($urandom_range(0, 9) == 0)
          data_pkt(16'(chunk), chunk + $urandom_range(0, 2) - 1, $urandom_range(0, 3));
        else data_pkt(16'(chunk), chunk, 0);
        rem -= chunk;
      end
      if ($urandom_range(0, 9) == 0) new_name($urandom_range(0, 4));
      if ($urandom_range(0, 9) == 0) cur_size = 64'($urandom_range(0, 12));
      bad = $urandom_range(0, 9) == 0;
      ctl_pkt(sb.cfg.end_code, !bad || $urandom_range(0, 1), !bad || $urandom_range(0, 1),
              size_bytes(cur_size) + $urandom_range(0, 1), $urandom_range(0, 9) == 0,
              bad ? $urandom_range(1, 6) : 0, $urandom_range(0, 4) == 0);
    end else begin
      case ($urandom_range(0, 2))
        0: unk_pkt($urandom_range(1, 5));
        1: data_pkt(16'($urandom_range(0, 5)), $urandom_range(0, 6), $urandom_range(0, 4));
        default: begin
          new_name($urandom_range(0, 5));
          cur_size = {$urandom, $urandom};
          ctl_pkt($urandom_range(0, 1) ? sb.cfg.start_code : sb.cfg.end_code,
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 12), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 8), 1'($urandom_range(0, 1)));
        end
      endcase
    end
  endtask

  task automatic run_phase(input int n);
    int stop;
    stop = n_sent + n;
    while (n_sent < stop) rand_transfer();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_value = '0;
    quiet = 0;
    hold_req = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed
    unk_pkt(1);
    unk_pkt(3);
    data_pkt(16'd2, 2, 0);
    data_pkt(16'd0, 0, 1);
    data_pkt(16'd5, 0, 2);
    new_name(3); cur_size = 64'd4;
    ctl_pkt(sb.cfg.start_code, 1'b1, 1'b1, 2, 1'b0, 0, 1'b1);
    pkt_q = '{sb.cfg.data_code, 8'h00, 8'h04, 8'h00, 8'hFF, 8'hA5, 8'h5A};
    send_pkt();
    data_pkt(16'd2, 5, 0);
    data_pkt(16'd3, 1, 0);
    data_pkt(16'hFFFF, 3, 0);
    ctl_pkt(sb.cfg.end_code, 1'b1, 1'b1, 1, 1'b1, 0, 1'b0);
    ctl_pkt(sb.cfg.start_code, 1'b0, 1'b1, 1, 1'b0, 0, 1'b0);
    ctl_pkt(sb.cfg.start_code, 1'b1, 1'b0, 1, 1'b0, 0, 1'b0);
    ctl_pkt(sb.cfg.start_code, 1'b1, 1'b1, 3, 1'b0, 4, 1'b0);
    new_name(0); cur_size = 64'd0;
    ctl_pkt(sb.cfg.start_code, 1'b1, 1'b1, 0, 1'b1, 0, 1'b0);
    cur_size = 64'hFFFF_FFFF_FFFF_FFFF;
    ctl_pkt(sb.cfg.start_code, 1'b1, 1'b1, 10, 1'b0, 0, 1'b0);
    new_name(2);
    ctl_pkt(sb.cfg.end_code, 1'b1, 1'b1, 8, 1'b0, 0, 1'b0);

    run_phase(250);
    hold_req = 1;
    run_phase(150);
    set_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    run_phase(150);
    set_codes(8'h00, 8'hFF, 8'h80, 8'hFF, 8'h00);
    quiet = 1;
    run_phase(200);
    quiet = 0;
    set_codes(8'h07, 8'h07, 8'h07, 8'h09, 8'h09);
    run_phase(60);
    set_codes(8'h10, 8'h20, 8'h20, 8'h05, 8'h06);
    run_phase(60);
    set_codes(8'd2, 8'd1, 8'd3, 8'd0, 8'd1);
    run_phase(250);

    drain();
    repeat (10) @(posedge clk);
    $display("%0d bytes in, %0d results checked over six register settings,",
             n_in, n_out);
    $display("with a long output hold-off and a stretch with no idling");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("file_transfer_packet_receiver_test OK");
    end else begin
      $display("file_transfer_packet_receiver_test NOT OK");
    end
    $finish;
  end

endmodule
